### src/tid_pkg.sv
// Shared types and codes for the TGA image decoder.
// No dependencies; imported by tid_front, tid_back and the top level.
`default_nettype none

package tid_pkg;

    // depth of the queue between the byte parser and the pixel placer
    localparam int TID_QUEUE_DEPTH = 4;

    // result status codes
    localparam logic [1:0] STATUS_PIXEL      = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE   = 2'd1;
    localparam logic [1:0] STATUS_BAD_FORMAT = 2'd2;

    // queue item kinds
    localparam logic [1:0] KIND_START = 2'd0;  // new image: colour = {width, height-1}
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] colour;   // {red, green, blue, alpha}
        logic [7:0]  count;
        logic        last;
    } t_item;

endpackage

`default_nettype wire

### src/tid_front.sv
// Byte parser: header checks, ID skip, packet headers and pixel assembly.
// Uses tid_pkg; emits at most one queue item per accepted byte.
`default_nettype none

module tid_front
    import tid_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_file_start,
    output logic            o_item_valid,
    output t_item           o_item
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_IDSKIP = 3'd1;
    localparam logic [2:0] PH_PKTHDR = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_FAULT  = 3'd5;

    localparam logic [4:0] HDR_LEN   = 5'd18;
    localparam logic [3:0] KIND_RLE  = 4'd10;

    logic [2:0]  r_phase,  n_phase;
    logic [4:0]  r_hidx,   n_hidx;
    logic [7:0]  r_idskip, n_idskip;
    logic [3:0]  r_kind,   n_kind;
    logic [5:0]  r_bpp,    n_bpp;
    logic [15:0] r_width,  n_width;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_pleft,  n_pleft;
    logic        r_is_run, n_is_run;
    logic [7:0]  r_cb [3];
    logic [7:0]  n_cb [3];
    logic [1:0]  r_ci,     n_ci;
    logic        r_type_bad, n_type_bad;
    logic        r_cmap_bad, n_cmap_bad;
    logic        r_size_bad, n_size_bad;
    logic [31:0] r_left,   n_left;     // pixels still to place

    logic [31:0] area;
    logic [7:0]  px_n;
    logic [7:0]  px_clip;
    logic        need4;

    assign area = r_width * r_height;

    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_idskip   = r_idskip;
        n_kind     = r_kind;
        n_bpp      = r_bpp;
        n_width    = r_width;
        n_height   = r_height;
        n_pleft    = r_pleft;
        n_is_run   = r_is_run;
        n_cb       = r_cb;
        n_ci       = r_ci;
        n_type_bad = r_type_bad;
        n_cmap_bad = r_cmap_bad;
        n_size_bad = r_size_bad;
        n_left     = r_left;
        o_item_valid = 1'b0;
        o_item       = '0;
        px_n    = 8'd1;
        px_clip = 8'd1;
        need4   = 1'b0;

        if (i_accept) begin
            if (i_file_start) begin
                n_phase    = PH_HEADER;
                n_hidx     = '0;
                n_idskip   = '0;
                n_kind     = '0;
                n_bpp      = '0;
                n_width    = '0;
                n_height   = '0;
                n_pleft    = '0;
                n_is_run   = 1'b0;
                n_cb       = '{default: 8'd0};
                n_ci       = '0;
                n_type_bad = 1'b0;
                n_cmap_bad = 1'b0;
                n_size_bad = 1'b0;
                n_left     = '0;
            end

            unique case (n_phase)
                PH_HEADER: begin
                    unique case (n_hidx)
                        5'd0:  n_idskip = i_data_byte;
                        5'd1:  n_cmap_bad = (i_data_byte != 8'd0);
                        5'd2: begin
                            n_type_bad = !(i_data_byte == 8'd2 || i_data_byte == 8'd10);
                            n_kind     = i_data_byte[3:0];
                        end
                        5'd12: n_width[7:0]   = i_data_byte;
                        5'd13: n_width[15:8]  = i_data_byte;
                        5'd14: n_height[7:0]  = i_data_byte;
                        5'd15: n_height[15:8] = i_data_byte;
                        5'd16: begin
                            n_size_bad = !(i_data_byte == 8'd24 || i_data_byte == 8'd32);
                            n_bpp      = i_data_byte[5:0];
                        end
                        default: ;
                    endcase
                    n_hidx = n_hidx + 5'd1;
                    if (n_hidx == HDR_LEN) begin
                        if (n_type_bad || n_cmap_bad || n_size_bad) begin
                            o_item_valid  = 1'b1;
                            o_item.kind   = KIND_FAULT;
                            o_item.status = n_type_bad ? STATUS_BAD_TYPE : STATUS_BAD_FORMAT;
                            n_phase       = PH_FAULT;
                        end else if (n_width == 16'd0 || n_height == 16'd0) begin
                            n_phase = PH_DONE;
                        end else if (n_idskip != 8'd0) begin
                            n_phase = PH_IDSKIP;
                        end else begin
                            o_item_valid  = 1'b1;
                            o_item.kind   = KIND_START;
                            o_item.colour = {r_width, r_height - 16'd1};
                            n_ci     = '0;
                            n_is_run = 1'b0;
                            n_pleft  = '0;
                            n_left   = area;
                            n_phase  = (n_kind == KIND_RLE) ? PH_PKTHDR : PH_PIXEL;
                        end
                    end
                end
                PH_IDSKIP: begin
                    n_idskip = n_idskip - 8'd1;
                    if (n_idskip == 8'd0) begin
                        o_item_valid  = 1'b1;
                        o_item.kind   = KIND_START;
                        o_item.colour = {r_width, r_height - 16'd1};
                        n_ci     = '0;
                        n_is_run = 1'b0;
                        n_pleft  = '0;
                        n_left   = area;
                        n_phase  = (n_kind == KIND_RLE) ? PH_PKTHDR : PH_PIXEL;
                    end
                end
                PH_PKTHDR: begin
                    n_is_run = i_data_byte[7];
                    n_pleft  = {1'b0, i_data_byte[6:0]} + 8'd1;
                    n_ci     = '0;
                    n_phase  = PH_PIXEL;
                end
                PH_PIXEL: begin
                    need4 = (n_bpp == 6'd32);
                    if (n_ci != (need4 ? 2'd3 : 2'd2)) begin
                        n_cb[n_ci] = i_data_byte;
                        n_ci       = n_ci + 2'd1;
                    end else begin
                        n_ci = '0;
                        px_n = (n_kind == KIND_RLE && n_is_run) ? n_pleft : 8'd1;
                        if (px_n == 8'd0) begin
                            px_n = 8'd1;
                        end
                        // clip a run to what is left of the image
                        px_clip = ({24'd0, px_n} > n_left) ? n_left[7:0] : px_n;
                        o_item_valid  = 1'b1;
                        o_item.kind   = KIND_PIXEL;
                        o_item.status = STATUS_PIXEL;
                        o_item.colour = {need4 ? n_cb[2] : i_data_byte, n_cb[1], n_cb[0],
                                         need4 ? i_data_byte : 8'hFF};
                        o_item.count  = px_clip;
                        o_item.last   = ({24'd0, px_clip} >= n_left);
                        if (o_item.last) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_left = n_left - {24'd0, px_clip};
                            if (n_kind == KIND_RLE) begin
                                if (n_is_run) begin
                                    n_phase = PH_PKTHDR;
                                end else begin
                                    n_pleft = n_pleft - 8'd1;
                                    if (n_pleft == 8'd0) begin
                                        n_phase = PH_PKTHDR;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;  // done or fault: bytes dropped until file start
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hidx     <= '0;
            r_idskip   <= '0;
            r_kind     <= '0;
            r_bpp      <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_pleft    <= '0;
            r_is_run   <= 1'b0;
            r_cb       <= '{default: 8'd0};
            r_ci       <= '0;
            r_type_bad <= 1'b0;
            r_cmap_bad <= 1'b0;
            r_size_bad <= 1'b0;
            r_left     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_idskip   <= n_idskip;
            r_kind     <= n_kind;
            r_bpp      <= n_bpp;
            r_width    <= n_width;
            r_height   <= n_height;
            r_pleft    <= n_pleft;
            r_is_run   <= n_is_run;
            r_cb       <= n_cb;
            r_ci       <= n_ci;
            r_type_bad <= n_type_bad;
            r_cmap_bad <= n_cmap_bad;
            r_size_bad <= n_size_bad;
            r_left     <= n_left;
        end
    end

endmodule

`default_nettype wire

### src/tid_fifo.sv
// Small register queue between the parser and the pixel placer.
// Generic width and depth; no package dependency.
`default_nettype none

module tid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // the parser never offers an item unless the queue has room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

### src/tid_back.sv
// Pixel placer: tracks buffer row/column and drives the result register.
// Uses tid_pkg; long runs divide the column offset by width, one bit a cycle.
`default_nettype none

module tid_back
    import tid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_item_valid,
    input  wire t_item       i_item,
    output logic             o_item_take,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [1:0]       o_status,
    output logic [15:0]      o_pixel_row,
    output logic [15:0]      o_pixel_column,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [7:0]       o_repeat_count,
    output logic             o_image_last
);

    logic        r_ovalid;
    logic [15:0] r_row, r_col, r_w;
    logic        r_busy;
    logic [16:0] r_rem;
    logic [7:0]  r_q;
    logic [2:0]  r_bit;

    logic        slot_free;
    logic        load_out;
    logic [16:0] sum;
    logic [16:0] sum_less_w;
    logic [24:0] w_shift;
    logic [16:0] n_rem;
    logic [7:0]  n_q;

    assign slot_free   = !r_ovalid || i_pop;
    assign o_item_take = i_item_valid && !r_busy && slot_free;
    assign o_empty     = !r_ovalid;
    // pixel and fault items fill the result register; a start item does not
    assign load_out    = o_item_take &&
                         (i_item.kind == KIND_PIXEL || i_item.kind == KIND_FAULT);

    assign sum        = {1'b0, r_col} + {9'd0, i_item.count};
    assign sum_less_w = sum - {1'b0, r_w};

    // one restoring division step
    always_comb begin
        w_shift = {9'd0, r_w} << r_bit;
        n_rem   = r_rem;
        n_q     = r_q;
        if ({8'd0, r_rem} >= w_shift) begin
            n_rem        = r_rem - w_shift[16:0];
            n_q[r_bit]   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_bit <= r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    r_busy <= 1'b0;
                    r_col  <= n_rem[15:0];
                    r_row  <= r_row - {8'd0, n_q};
                end
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end

            if (o_item_take) begin
                unique case (i_item.kind)
                    KIND_START: begin
                        r_w   <= i_item.colour[31:16];
                        r_row <= i_item.colour[15:0];
                        r_col <= '0;
                    end
                    KIND_PIXEL: begin
                        o_status       <= STATUS_PIXEL;
                        o_pixel_row    <= r_row;
                        o_pixel_column <= r_col;
                        {o_red, o_green, o_blue, o_alpha} <= i_item.colour;
                        o_repeat_count <= i_item.count;
                        o_image_last   <= i_item.last;
                        if (!i_item.last) begin
                            if (sum < {1'b0, r_w}) begin
                                r_col <= sum[15:0];
                            end else if (sum_less_w < {1'b0, r_w}) begin
                                r_col <= sum_less_w[15:0];
                                r_row <= r_row - 16'd1;
                            end else begin
                                // run spans several rows
                                r_busy <= 1'b1;
                                r_rem  <= sum;
                                r_q    <= '0;
                                r_bit  <= 3'd7;
                            end
                        end
                    end
                    KIND_FAULT: begin
                        o_status       <= i_item.status;
                        o_pixel_row    <= '0;
                        o_pixel_column <= '0;
                        {o_red, o_green, o_blue, o_alpha} <= '0;
                        o_repeat_count <= '0;
                        o_image_last   <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // a multi-row run only happens for images narrower than a run
    a_div_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_w < 16'd128 && r_w != 16'd0))
        else $error("division started on a wide image");

    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_item_take)
        else $error("queue item taken during division");

endmodule

`default_nettype wire

### src/tga_image_decoder.sv
// Top level of the TGA true-colour decoder: parser, queue, pixel placer.
// Uses tid_pkg, tid_front, tid_fifo and tid_back.
`default_nettype none

// Channel   Direction  Handshake               Payload
// -------   ---------  ---------------------   ---------------------------------------
// bytes     in         push / full             i_data_byte, i_file_start
// results   out        empty / pop             o_status, o_pixel_row, o_pixel_column,
//                                              o_red/green/blue/alpha, o_repeat_count,
//                                              o_image_last
//
// One file byte is taken per cycle while full is low; the parser updates its
// counters in the accepting cycle and posts at most one transaction into the queue.
// A result is in the output register the cycle after its item leaves the queue.
// A run that wraps past the next row keeps the placer busy for an 8-step
// divide of the column offset by the width; the queue absorbs this.
// full rises only when the queue is full; a stalled pop stalls the placer, and bytes once the queue fills.
// Synchronous active-low reset; no clearing pass is needed.

module tga_image_decoder
    import tid_pkg::*;
#(
    parameter int QUEUE_DEPTH = TID_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_file_start,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [15:0]      o_pixel_row,
    output logic [15:0]      o_pixel_column,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [7:0]       o_repeat_count,
    output logic             o_image_last
);

    logic  accept;
    logic  front_valid;
    t_item front_item;
    logic  q_valid;
    t_item q_item;
    logic  q_take;

    assign accept = push && !full;

    tid_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_item_valid (front_valid),
        .o_item       (front_item)
    );

    // the parser posts only on an accepted byte, and bytes are refused when full
    tid_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_wdata (front_item),
        .o_full  (full),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_rdata (q_item)
    );

    tid_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_item),
        .o_item_take    (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_status       (o_status),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_column (o_pixel_column),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_repeat_count (o_repeat_count),
        .o_image_last   (o_image_last)
    );

endmodule

`default_nettype wire
